// ===== design/tti_pkg.sv =====
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types and codes of the trajectory time interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_EXACT  = 3'd1;
    localparam logic [2:0] ST_INTERP = 3'd2;
    localparam logic [2:0] ST_BEFORE = 3'd3;
    localparam logic [2:0] ST_AFTER  = 3'd4;
    localparam logic [2:0] ST_FEW    = 3'd5;
    localparam logic [2:0] ST_FULL   = 3'd6;

    typedef struct packed {
        logic [1:0]         command;
        logic [47:0]        sample_time;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_cmd_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [2:0]         status;
        logic               clipped;
    } t_res_item;

    typedef struct packed {
        logic wr_new;
        logic shift;
        logic inj;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_COLLECT,
        S_START,
        S_CALC,
        S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } t_lane_state;

endpackage

// ===== design/tti_stream_if.sv =====
// ----------------------------------------------------------------------------
// tti_stream_if
// Valid/ready stream channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface tti_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/tti_cell.sv =====
// ----------------------------------------------------------------------------
// tti_cell
// One table slot: holds a sample, compares it with the key and forwards a
// read word along the drain chain.
// ----------------------------------------------------------------------------
module tti_cell
    import tti_pkg::*;
#(
    parameter int TW = 48,
    parameter int CW = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic                   i_valid,
    input  logic [TW-1:0]          i_tq,
    input  logic [TW+3*CW-1:0]     i_new,
    input  logic [TW+3*CW-1:0]     i_prev,
    input  logic                   i_chain_v,
    input  logic [TW+3*CW-1:0]     i_chain_d,
    output logic [TW+3*CW-1:0]     o_entry,
    output logic                   o_chain_v,
    output logic [TW+3*CW-1:0]     o_chain_d,
    output logic                   o_less,
    output logic                   o_hit
);
    localparam int EW = TW + 3 * CW;

    logic [EW-1:0] r_entry;
    logic          r_chain_v;
    logic [EW-1:0] r_chain_d;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_new) begin
            r_entry <= i_new;
        end else if (i_ctrl.shift) begin
            r_entry <= i_prev;
        end
        r_chain_d <= i_ctrl.inj ? r_entry : i_chain_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_v <= 1'b0;
        end else begin
            r_chain_v <= i_ctrl.inj | i_chain_v;
        end
    end

    assign o_entry   = r_entry;
    assign o_chain_v = r_chain_v;
    assign o_chain_d = r_chain_d;
    assign o_less    = i_valid && (r_entry[EW-1 -: TW] < i_tq);
    assign o_hit     = i_valid && (r_entry[EW-1 -: TW] == i_tq);

endmodule

// ===== design/tti_lane.sv =====
// ----------------------------------------------------------------------------
// tti_lane
// One coordinate: serial multiply, serial restoring divide, rounding and
// saturation of pa + (pb - pa) * n / den.
// ----------------------------------------------------------------------------
module tti_lane
    import tti_pkg::*;
#(
    parameter int TW         = 48,
    parameter int CW         = 32,
    parameter int COORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW-1:0] i_pa,
    input  logic signed [CW-1:0] i_pb,
    input  logic [TW-1:0]        i_n,
    input  logic [TW-1:0]        i_den,
    input  logic                 i_back,
    output logic                 o_done,
    output logic [31:0]          o_value,
    output logic                 o_clip
);
    localparam int MW = CW + 1;
    localparam int PW = MW + TW;
    localparam int QW = (PW + 1 > 54) ? PW + 1 : 54;
    localparam int VW = 56;
    localparam int KW = $clog2(PW + 1);
    localparam logic signed [VW-1:0] C_HI = VW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] C_LO = -C_HI - VW'(1);

    t_lane_state r_state, n_state;
    logic [KW-1:0]        r_cnt;
    logic [PW-1:0]        r_mcand;
    logic [TW-1:0]        r_mplier;
    logic [PW-1:0]        r_acc;
    logic [TW-1:0]        r_rem;
    logic [TW-1:0]        r_den;
    logic signed [CW-1:0] r_pa;
    logic                 r_neg;
    logic [31:0]          r_value;
    logic                 r_clip;
    logic                 r_done;

    logic signed [CW:0]     w_diff;
    logic [MW-1:0]          w_mag;
    logic [TW:0]            w_r2;
    logic                   w_ge;
    logic [TW:0]            w_r2s;
    logic                   w_round;
    logic [QW-1:0]          w_q;
    logic                   w_big;
    logic signed [VW-1:0]   w_qv;
    logic signed [VW-1:0]   w_pav;
    logic signed [VW-1:0]   w_v;
    logic signed [VW-1:0]   w_sat;
    logic                   w_sat_clip;
    logic                   w_mul_step;
    logic                   w_div_step;
    logic                   w_fin;

    assign w_diff  = (CW + 1)'(i_pb) - (CW + 1)'(i_pa);
    assign w_mag   = MW'(w_diff[CW] ? -w_diff : w_diff);
    assign w_r2    = {r_rem, r_acc[PW-1]};
    assign w_ge    = w_r2 >= {1'b0, r_den};
    assign w_r2s   = w_r2 - {1'b0, r_den};
    assign w_round = {r_rem, 1'b0} >= {1'b0, r_den};
    assign w_q     = QW'(r_acc) + QW'(w_round);
    assign w_big   = w_q > (QW'(1) << 52);
    assign w_qv    = VW'(w_q[52:0]);
    assign w_pav   = VW'(r_pa);
    assign w_v     = r_neg ? (w_pav - w_qv) : (w_pav + w_qv);

    always_comb begin
        w_sat      = w_v;
        w_sat_clip = 1'b0;
        if (w_big) begin
            w_sat      = r_neg ? C_LO : C_HI;
            w_sat_clip = 1'b1;
        end else if (w_v > C_HI) begin
            w_sat      = C_HI;
            w_sat_clip = 1'b1;
        end else if (w_v < C_LO) begin
            w_sat      = C_LO;
            w_sat_clip = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: if (i_start) n_state = L_MUL;
            L_MUL:  if (r_cnt == KW'(TW - 1)) n_state = L_DIV;
            L_DIV:  if (r_cnt == KW'(PW - 1)) n_state = L_FIN;
            L_FIN:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_comb begin
        w_mul_step = 1'b0;
        w_div_step = 1'b0;
        w_fin      = 1'b0;
        case (r_state)
            L_MUL:   w_mul_step = 1'b1;
            L_DIV:   w_div_step = 1'b1;
            L_FIN:   w_fin      = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_mcand  <= PW'(w_mag);
            r_mplier <= i_n;
            r_acc    <= '0;
            r_rem    <= '0;
            r_den    <= i_den;
            r_pa     <= i_pa;
            r_neg    <= w_diff[CW] != i_back;
            r_cnt    <= '0;
        end
        if (w_mul_step) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
            r_cnt    <= (r_cnt == KW'(TW - 1)) ? '0 : r_cnt + KW'(1);
        end
        if (w_div_step) begin
            // shift the product out at the top, quotient bits in at the bottom
            r_rem <= TW'(w_ge ? w_r2s : w_r2);
            r_acc <= {r_acc[PW-2:0], w_ge};
            r_cnt <= r_cnt + KW'(1);
        end
        if (w_fin) begin
            r_value <= w_sat[31:0];
            r_clip  <= w_sat_clip;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule

// ===== design/trajectory_time_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// trajectory_time_interpolator_unit
// Time-sorted sample table with exact lookup, linear interpolation and
// extrapolation of (x, y, z) at a query time.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd_if takes one command per transaction (load, query, clear); o_res_if
//   returns exactly one result per command, in order. The block works on one
//   command at a time; i_cmd_if.ready is high while it waits for a command.
//   The table is a row of TABLE_DEPTH cells. A load compares all cells at
//   once and shifts the tail one cell up, or overwrites a cell whose time
//   matches; a full table takes no new time. A clear sets the count to zero.
//   Both pass S_EVAL and S_PUSH before the result is registered, as does a
//   query with fewer than two samples. A query with a time match also waits
//   in S_COLLECT while the matching cell's word drains along the read chain
//   to the tail. An interpolating or extrapolating query also runs the three
//   coordinate lanes on the drained pair: a serial multiply of TIME_BITS
//   steps and a serial divide of TIME_BITS + min(COORD_BITS,32) + 1 steps.
//   The next command can be taken in the same cycle as the result is offered.
//   The result register holds a result while o_res_if.ready is low; a new
//   command is taken meanwhile and its result waits until the register frees.
//   Reset empties the table at once (count to zero); no clearing pass.
// ----------------------------------------------------------------------------
module trajectory_time_interpolator_unit
    import tti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int TIME_BITS   = 48,
    parameter int COORD_BITS  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tti_stream_if.sink         i_cmd_if,
    tti_stream_if.source       o_res_if
);
    localparam int TW   = TIME_BITS;
    localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int EW   = TW + 3 * CW;
    localparam int D    = TABLE_DEPTH;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;
    logic [1:0]      r_cmd;
    logic [TW-1:0]   r_tq;
    logic [EW-1:0]   r_new;
    logic [CNTW-1:0] r_count;
    logic            r_need2;
    logic            r_got;
    logic [2:0]      r_kind;
    logic [EW-1:0]   r_wa;
    logic [EW-1:0]   r_wb;
    t_res_item       r_res;
    t_res_item       r_out;
    logic            r_out_valid;

    t_cmd_item       w_in;
    logic            w_accept;
    logic            w_push;
    logic            w_start;
    logic [EW-1:0]   w_entry [D];
    logic            w_cv [D];
    logic [EW-1:0]   w_cd [D];
    logic [D-1:0]    w_less;
    logic [D-1:0]    w_hit;
    logic [D-1:0]    w_last;
    logic [D-1:0]    w_bnd;
    logic            w_anyhit;
    logic            w_after;
    logic            w_before;
    logic            w_full;
    logic            w_load_go;
    logic            w_query_go;
    logic            w_tail_v;
    logic [EW-1:0]   w_tail;
    logic [TW-1:0]   w_ta;
    logic [TW-1:0]   w_tb;
    logic [TW-1:0]   w_n;
    logic [TW-1:0]   w_den;
    logic            w_back;
    logic [2:0]      w_done;
    logic [31:0]     w_val [3];
    logic [2:0]      w_clip;
    logic [2:0]      w_eval_status;

    assign w_in       = i_cmd_if.payload;
    assign w_accept   = i_cmd_if.valid && i_cmd_if.ready;
    assign w_anyhit   = |w_hit;
    assign w_after    = |(w_less & w_last);
    assign w_before   = !w_less[0];
    assign w_full     = r_count == CNTW'(D);
    assign w_load_go  = (r_state == S_EVAL) && (r_cmd == CMD_LOAD);
    assign w_query_go = (r_state == S_EVAL) && (r_cmd == CMD_QUERY) && (r_count >= CNTW'(2));
    assign w_tail_v   = w_cv[D-1];
    assign w_tail     = w_cd[D-1];

    // ---- cell row ----
    genvar gi;
    generate
        for (gi = 0; gi < D; gi++) begin : g_cell
            t_cell_ctrl w_ctrl;
            logic       w_prev_less;
            logic       w_prev_bnd;
            logic       w_next_less;
            logic       w_tail_sel;

            if (gi == 0) begin : g_first
                assign w_prev_less = 1'b0;
                assign w_prev_bnd  = 1'b0;
            end else begin : g_mid
                assign w_prev_less = w_less[gi-1];
                assign w_prev_bnd  = w_bnd[gi-1];
            end
            if (gi == D - 1) begin : g_end
                assign w_next_less = 1'b0;
            end else begin : g_inner
                assign w_next_less = w_less[gi+1];
            end

            assign w_last[gi]  = (CNTW + 1)'(gi + 1) == {1'b0, r_count};
            assign w_bnd[gi]   = w_less[gi] && !w_next_less;
            assign w_tail_sel  = ((CNTW + 1)'(gi + 2) == {1'b0, r_count}) || w_last[gi];

            always_comb begin
                w_ctrl = '0;
                if (w_load_go) begin
                    if (w_anyhit) begin
                        w_ctrl.wr_new = w_hit[gi];
                    end else if (!w_full && !w_less[gi]) begin
                        w_ctrl.wr_new = (gi == 0) || w_prev_less;
                        w_ctrl.shift  = (gi != 0) && !w_prev_less;
                    end
                end
                if (w_query_go) begin
                    if (w_anyhit) begin
                        w_ctrl.inj = w_hit[gi];
                    end else if (w_before) begin
                        w_ctrl.inj = gi <= 1;
                    end else if (w_after) begin
                        w_ctrl.inj = w_tail_sel;
                    end else begin
                        w_ctrl.inj = w_bnd[gi] || w_prev_bnd;
                    end
                end
            end

            tti_cell #(
                .TW (TW),
                .CW (CW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_valid   (CNTW'(gi) < r_count),
                .i_tq      (r_tq),
                .i_new     (r_new),
                .i_prev    ((gi == 0) ? '0 : w_entry[(gi == 0) ? 0 : gi - 1]),
                .i_chain_v ((gi == 0) ? 1'b0 : w_cv[(gi == 0) ? 0 : gi - 1]),
                .i_chain_d ((gi == 0) ? '0 : w_cd[(gi == 0) ? 0 : gi - 1]),
                .o_entry   (w_entry[gi]),
                .o_chain_v (w_cv[gi]),
                .o_chain_d (w_cd[gi]),
                .o_less    (w_less[gi]),
                .o_hit     (w_hit[gi])
            );
        end
    endgenerate

    // ---- coordinate lanes; the upper cell of the pair drains first ----
    assign w_ta   = r_wa[EW-1 -: TW];
    assign w_tb   = r_wb[EW-1 -: TW];
    assign w_back = r_kind == ST_BEFORE;
    assign w_n    = w_back ? (w_ta - r_tq) : (r_tq - w_ta);
    assign w_den  = w_tb - w_ta;

    generate
        for (gi = 0; gi < 3; gi++) begin : g_lane
            tti_lane #(
                .TW         (TW),
                .CW         (CW),
                .COORD_BITS (COORD_BITS)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (w_start),
                .i_pa    (r_wa[(3 - gi) * CW - 1 -: CW]),
                .i_pb    (r_wb[(3 - gi) * CW - 1 -: CW]),
                .i_n     (w_n),
                .i_den   (w_den),
                .i_back  (w_back),
                .o_done  (w_done[gi]),
                .o_value (w_val[gi]),
                .o_clip  (w_clip[gi])
            );
        end
    endgenerate

    // ---- control ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_accept) n_state = S_EVAL;
            S_EVAL:    n_state = w_query_go ? S_COLLECT : S_PUSH;
            S_COLLECT: begin
                if (w_tail_v) begin
                    if (!r_need2) n_state = S_PUSH;
                    else if (r_got) n_state = S_START;
                end
            end
            S_START:   n_state = S_CALC;
            S_CALC:    if (w_done[0]) n_state = S_PUSH;
            S_PUSH:    if (!r_out_valid || o_res_if.ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_cmd_if.ready = 1'b0;
        w_start        = 1'b0;
        w_push         = 1'b0;
        case (r_state)
            S_IDLE:  i_cmd_if.ready = 1'b1;
            S_START: w_start = 1'b1;
            S_PUSH:  w_push = !r_out_valid || o_res_if.ready;
            default: ;
        endcase
    end

    always_comb begin
        w_eval_status = ST_DONE;
        if (r_cmd == CMD_LOAD && !w_anyhit && w_full) begin
            w_eval_status = ST_FULL;
        end
        if (r_cmd == CMD_QUERY && r_count < CNTW'(2)) begin
            w_eval_status = ST_FEW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_go && !w_anyhit && !w_full) begin
                r_count <= r_count + CNTW'(1);
            end
            if (r_state == S_EVAL && r_cmd == CMD_CLEAR) begin
                r_count <= '0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_in.command;
            r_tq  <= TW'(w_in.sample_time);
            r_new <= {TW'(w_in.sample_time), CW'(w_in.in_x), CW'(w_in.in_y), CW'(w_in.in_z)};
        end
        if (r_state == S_EVAL) begin
            r_res   <= '{out_x: '0, out_y: '0, out_z: '0, status: w_eval_status,
                         clipped: 1'b0};
            r_got   <= 1'b0;
            r_need2 <= !w_anyhit;
            if (r_cmd == CMD_QUERY) begin
                if (w_anyhit) begin
                    r_kind <= ST_EXACT;
                end else if (w_before) begin
                    r_kind <= ST_BEFORE;
                end else if (w_after) begin
                    r_kind <= ST_AFTER;
                end else begin
                    r_kind <= ST_INTERP;
                end
            end
        end
        if (r_state == S_COLLECT && w_tail_v) begin
            if (!r_got) begin
                r_wb  <= w_tail;
                r_got <= 1'b1;
            end else begin
                r_wa <= w_tail;
            end
            if (!r_need2) begin
                r_res.out_x  <= 32'($signed(w_tail[3*CW-1 -: CW]));
                r_res.out_y  <= 32'($signed(w_tail[2*CW-1 -: CW]));
                r_res.out_z  <= 32'($signed(w_tail[CW-1 -: CW]));
                r_res.status <= ST_EXACT;
            end
        end
        if (r_state == S_CALC && w_done[0]) begin
            r_res.out_x   <= w_val[0];
            r_res.out_y   <= w_val[1];
            r_res.out_z   <= w_val[2];
            r_res.status  <= r_kind;
            r_res.clipped <= |w_clip;
        end
        if (w_push) begin
            r_out <= r_res;
        end
    end

    assign o_res_if.valid   = r_out_valid;
    assign o_res_if.payload = r_out;

    // ---- checks ----
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(D))
        else $error("sample count beyond table depth");

    a_chain_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_v |-> r_state == S_COLLECT)
        else $error("read chain word outside collect phase");

    a_clip_extrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_if.valid && o_res_if.payload.clipped) |->
        (o_res_if.payload.status == ST_BEFORE || o_res_if.payload.status == ST_AFTER))
        else $error("clipping flagged on a non-extrapolated result");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_cmd == CMD_CLEAR) |=> r_count == '0)
        else $error("clear did not empty the table");

endmodule
